@@ hw/rtl/ipv4cs_pkg.sv @@
// Shared types, constants and one's-complement helper for the IPv4/TCP checksum engine.
`default_nettype none
package ipv4cs_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;

  // Byte positions inside a packet with a 20-byte IPv4 header
  localparam logic [15:0] HDR_BYTES      = 16'd20;
  localparam logic [15:0] POS_PROTOCOL   = 16'd9;
  localparam logic [15:0] POS_IP_CSUM_HI = 16'd10;
  localparam logic [15:0] POS_IP_CSUM_LO = 16'd11;
  localparam logic [15:0] POS_PSEUDO_LO  = 16'd13;
  localparam logic [15:0] POS_TCP_CSUM_HI = 16'd36;
  localparam logic [15:0] POS_TCP_CSUM_LO = 16'd37;

  localparam logic [15:0] WORD_MASK = 16'hFFFF;
  localparam logic [15:0] HIGH_MASK = 16'hFF00;

  // Packet totals handed from the accumulator to the finishing stage
  typedef struct packed {
    logic [15:0] header_sum;
    logic [15:0] segment_sum;
    logic [7:0]  pending_high_byte;
    logic [15:0] byte_count;
  } pkt_totals_t;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0] & WORD_MASK;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ipv4cs_accum.sv @@
// Per-byte accumulator: position count, pending high byte, header and segment sums.
`default_nettype none
module ipv4cs_accum
  import ipv4cs_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  output logic             tot_valid,
  output pkt_totals_t      tot,
  input  wire logic        tot_ready
);

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      header_sum, header_sum_next;
  logic [15:0]      segment_sum, segment_sum_next;
  logic [7:0]       pending_high_byte, pending_high_byte_next;

  logic        accept;
  logic        tot_take;
  logic [15:0] pos;
  logic [7:0]  eb;
  logic [15:0] word;
  logic        odd;

  assign tot_take = tot_valid && tot_ready;
  assign in_stall = tot_valid && !tot_ready;
  assign accept   = in_valid && !in_stall;

  assign pos  = 16'(byte_position);
  assign odd  = byte_position[0];
  assign eb   = (pos == POS_IP_CSUM_HI || pos == POS_IP_CSUM_LO ||
                 pos == POS_TCP_CSUM_HI || pos == POS_TCP_CSUM_LO) ? 8'd0 : data_byte;
  assign word = {pending_high_byte, eb};

  always_comb begin
    byte_position_next     = byte_position;
    header_sum_next        = header_sum;
    segment_sum_next       = segment_sum;
    pending_high_byte_next = pending_high_byte;
    // bytes past the size limit are dropped, count saturates
    if (byte_position < POS_MAX) begin
      byte_position_next = byte_position + POS_W'(1);
      if (!odd) begin
        pending_high_byte_next = eb;
      end else if (pos < HDR_BYTES) begin
        header_sum_next = oc_add(header_sum, word);
      end
      // protocol byte (position 9, below the pseudo-header words) and
      // pseudo-header/segment words share one adder
      if (pos == POS_PROTOCOL) begin
        segment_sum_next = oc_add(segment_sum, {8'd0, eb});
      end else if (odd && pos >= POS_PSEUDO_LO) begin
        segment_sum_next = oc_add(segment_sum, word);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      header_sum        <= '0;
      segment_sum       <= '0;
      pending_high_byte <= '0;
      tot_valid         <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          byte_position     <= '0;
          header_sum        <= '0;
          segment_sum       <= '0;
          pending_high_byte <= '0;
        end else begin
          byte_position     <= byte_position_next;
          header_sum        <= header_sum_next;
          segment_sum       <= segment_sum_next;
          pending_high_byte <= pending_high_byte_next;
        end
      end
      if (accept && last) begin
        tot_valid <= 1'b1;
      end else if (tot_take) begin
        tot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      tot.header_sum        <= header_sum_next;
      tot.segment_sum       <= segment_sum_next;
      tot.pending_high_byte <= pending_high_byte_next;
      tot.byte_count        <= 16'(byte_position_next);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ipv4cs_finish.sv @@
// Final fold of pad and TCP length, complement or short-packet zeroing, and the output register.
`default_nettype none
module ipv4cs_finish
  import ipv4cs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tot_valid,
  input  pkt_totals_t      tot,
  output logic             tot_ready,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      ip_header_checksum,
  output logic [15:0]      tcp_segment_checksum,
  output logic             packet_too_short
);

  logic        take;
  logic        short_pkt;
  logic [15:0] pad_word;
  logic [15:0] tcp_len;
  logic [15:0] seg_pad;
  logic [15:0] seg_full;

  assign tot_ready = !out_valid || !out_stall;
  assign take      = tot_valid && tot_ready;

  assign short_pkt = tot.byte_count < HDR_BYTES;
  assign pad_word  = tot.byte_count[0] ? ({tot.pending_high_byte, 8'd0} & HIGH_MASK) : 16'd0;
  assign tcp_len   = (tot.byte_count - HDR_BYTES) & WORD_MASK;
  assign seg_pad   = oc_add(tot.segment_sum, pad_word);
  assign seg_full  = oc_add(seg_pad, tcp_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (short_pkt) begin
        ip_header_checksum   <= 16'd0;
        tcp_segment_checksum <= 16'd0;
        packet_too_short     <= 1'b1;
      end else begin
        ip_header_checksum   <= ~tot.header_sum;
        tcp_segment_checksum <= ~seg_full;
        packet_too_short     <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/ipv4_tcp_checksum_engine_unit.sv @@
// Top level of the IPv4/TCP checksum engine.
// Takes an IPv4 packet one byte per transaction on the input channel (20-byte
// header, no options) and, for the transaction that carries last, delivers one
// output transaction with the complemented IP header checksum and the TCP
// checksum over pseudo-header and segment. Checksum bytes 10/11 and 36/37 count
// as zero; an odd final byte is padded with a zero low byte. Packets under 20
// bytes give zero checksums with packet_too_short set. Bytes beyond
// MAX_PACKET_BYTES are dropped. One byte is taken every clock while in_stall
// is low: each byte costs at most one 16-bit end-around-carry add per sum in
// the accumulator. A result passes the totals register, then the finishing
// fold of pad and TCP length into the output register. in_stall is raised
// only while a finished packet total waits behind a stalled output register.
`default_nettype none
module ipv4_tcp_checksum_engine_unit
  import ipv4cs_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      ip_header_checksum,
  output logic [15:0]      tcp_segment_checksum,
  output logic             packet_too_short
);

  // packet totals between the two stages
  logic        tot_valid;
  logic        tot_ready;
  pkt_totals_t tot;

  ipv4cs_accum #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last      (last),
    .tot_valid (tot_valid),
    .tot       (tot),
    .tot_ready (tot_ready)
  );

  ipv4cs_finish u_finish (
    .clk                  (clk),
    .rst                  (rst),
    .tot_valid            (tot_valid),
    .tot                  (tot),
    .tot_ready            (tot_ready),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .ip_header_checksum   (ip_header_checksum),
    .tcp_segment_checksum (tcp_segment_checksum),
    .packet_too_short     (packet_too_short)
  );

endmodule
`default_nettype wire

@@ hw/rtl/ipv4cs_checker.sv @@
// Port-level checker for the IPv4/TCP checksum engine, bound to the top level.
`default_nettype none
module ipv4cs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] ip_header_checksum,
  input wire logic [15:0] tcp_segment_checksum,
  input wire logic        packet_too_short
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ip_header_checksum) &&
      $stable(tcp_segment_checksum) && $stable(packet_too_short))
    else $error("stalled output transaction changed");

  // short packets report zero checksums
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_too_short |-> ip_header_checksum == 16'd0 &&
      tcp_segment_checksum == 16'd0)
    else $error("short packet with nonzero checksum");

  // input backpressure only comes from a held output
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // nothing left over from before reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a rising result traces back to an accepted last byte, through the totals register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
    else $error("output valid rose without a last byte two cycles earlier");

endmodule

bind ipv4_tcp_checksum_engine_unit ipv4cs_checker u_ipv4cs_checker (
  .clk                  (clk),
  .rst                  (rst),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .last                 (last),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .ip_header_checksum   (ip_header_checksum),
  .tcp_segment_checksum (tcp_segment_checksum),
  .packet_too_short     (packet_too_short)
);
`default_nettype wire
